/* hw/rtl/gpt_pkg.sv */
package gpt_pkg;

	localparam int NumChannelsDef = 4;
	localparam int CountWidthDef = 16;

	typedef enum logic [1:0] {
		REQ_TICK = 2'd0,
		REQ_WRITE = 2'd1,
		REQ_READ = 2'd2,
		REQ_NONE = 2'd3
	} req_t;

	localparam logic [3:0] REG_CTRL = 4'd0;
	localparam logic [3:0] REG_IRQEN = 4'd1;
	localparam logic [3:0] REG_STATUS = 4'd2;
	localparam logic [3:0] REG_EVENT = 4'd3;
	localparam logic [3:0] REG_MODE01 = 4'd4;
	localparam logic [3:0] REG_MODE23 = 4'd5;
	localparam logic [3:0] REG_CHEN = 4'd6;
	localparam logic [3:0] REG_COUNT = 4'd7;
	localparam logic [3:0] REG_PSC = 4'd8;
	localparam logic [3:0] REG_RELOAD = 4'd9;
	localparam logic [3:0] REG_CMP0 = 4'd10;
	localparam logic [3:0] REG_CMP1 = 4'd11;
	localparam logic [3:0] REG_CMP2 = 4'd12;
	localparam logic [3:0] REG_CMP3 = 4'd13;
	localparam logic [3:0] REG_SLAVE = 4'd14;

	localparam logic [2:0] OC_PWM1 = 3'd6;

	typedef struct packed {
		logic [15:0] read_value;
		logic update_irq;
		logic dma_request;
		logic [3:0] pwm_outputs;
		logic [3:0] capture_flags;
		logic running;
	} result_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic [3:0] reg_index;
		logic [15:0] write_value;
		logic ext_clock_edge;
		logic [3:0] channel_pins;
	} request_t;

endpackage

/* hw/rtl/gpt_core.sv */
module gpt_core #(
	parameter int NUM_CHANNELS = 4,
	parameter int COUNT_WIDTH = 16
) (
	input logic clk,
	input logic arst_n,
	input logic req_fire,
	input gpt_pkg::request_t req_s1,
	output gpt_pkg::result_t res
);
	import gpt_pkg::*;

	localparam int NC = NUM_CHANNELS;
	localparam int CW = COUNT_WIDTH;

	logic [CW-1:0] cnt_q, cnt_d, reload_q, reload_d;
	logic [15:0] pcnt_q, pcnt_d, ppre_q, ppre_d, pact_q, pact_d;
	logic [3:0] ctrl_q, ctrl_d;
	logic [1:0] ien_q, ien_d;
	logic uf_q, uf_d;
	logic [NC-1:0] chf_q, chf_d, pins_q, pins_d;
	logic [7:0] mode_q [NC];
	logic [7:0] mode_d [NC];
	logic [3:0] chen_q [NC];
	logic [3:0] chen_d [NC];
	logic [CW-1:0] cmp_q [NC];
	logic [CW-1:0] cmp_d [NC];
	logic ext_q, ext_d;
	logic dma;
	logic [15:0] rd;
	logic [3:0] pwm;
	logic [CW-1:0] cnt_mid;

	function automatic logic [15:0] lo16(input logic [CW-1:0] v);
		logic [31:0] w;
		w = 32'(v);
		return w[15:0];
	endfunction

	always_comb begin
		logic upd, upd_ovf, step, inp, pol, np, prev, cur, hit;
		logic [3:0] chn;
		logic [31:0] wv;
		int ch;
		cnt_d = cnt_q;
		reload_d = reload_q;
		pcnt_d = pcnt_q;
		ppre_d = ppre_q;
		pact_d = pact_q;
		ctrl_d = ctrl_q;
		ien_d = ien_q;
		uf_d = uf_q;
		chf_d = chf_q;
		pins_d = pins_q;
		mode_d = mode_q;
		chen_d = chen_q;
		cmp_d = cmp_q;
		ext_d = ext_q;
		dma = 1'b0;
		rd = '0;
		upd = 1'b0;
		upd_ovf = 1'b0;
		step = 1'b0;
		wv = 32'(req_s1.write_value);
		chn = req_s1.reg_index - REG_CMP0;
		cnt_mid = cnt_q;
		if (req_fire) begin
			case (req_s1.req_type)
				REQ_TICK: begin
					for (int i = 0; i < NC; i++) begin
						inp = mode_q[i][1:0] != 2'd0;
						pol = chen_q[i][1];
						np = chen_q[i][3];
						prev = pins_q[i];
						cur = req_s1.channel_pins[i];
						hit = (((!pol || np) && !prev && cur) || (pol && prev && !cur));
						if (inp && chen_q[i][0] && hit) begin
							cmp_d[i] = cnt_q;
							chf_d[i] = 1'b1;
						end
					end
					pins_d = req_s1.channel_pins[NC-1:0];
					if (ctrl_q[0] && (!ext_q || req_s1.ext_clock_edge)) begin
						if (pcnt_q >= pact_q) begin
							pcnt_d = '0;
							step = 1'b1;
							if (cnt_q == reload_q) begin
								cnt_mid = '0;
								upd = 1'b1;
								upd_ovf = 1'b1;
							end else begin
								cnt_mid = cnt_q + 1'b1;
							end
							cnt_d = cnt_mid;
						end else begin
							pcnt_d = pcnt_q + 16'd1;
						end
					end
				end
				REQ_WRITE: begin
					unique case (req_s1.reg_index)
						REG_CTRL: ctrl_d = req_s1.write_value[3:0];
						REG_IRQEN: ien_d = {req_s1.write_value[8], req_s1.write_value[0]};
						REG_STATUS: begin
							uf_d = uf_q & req_s1.write_value[0];
							for (int i = 0; i < NC; i++)
								chf_d[i] = chf_q[i] & req_s1.write_value[i+1];
						end
						REG_EVENT: begin
							if (req_s1.write_value[0]) begin
								cnt_d = '0;
								pcnt_d = '0;
								upd = 1'b1;
							end
							for (int i = 0; i < NC; i++)
								if (req_s1.write_value[i+1]) begin
									if (mode_q[i][1:0] != 2'd0) cmp_d[i] = cnt_d;
									chf_d[i] = 1'b1;
								end
						end
						REG_MODE01, REG_MODE23: begin
							for (int i = 0; i < 2; i++) begin
								ch = (req_s1.reg_index == REG_MODE23) ? 2 + i : i;
								for (int k = 0; k < NC; k++)
									if (k == ch) mode_d[k] = wv[8*i +: 8];
							end
						end
						REG_CHEN: for (int i = 0; i < NC; i++) chen_d[i] = wv[4*i +: 4];
						REG_COUNT: cnt_d = CW'(req_s1.write_value);
						REG_PSC: ppre_d = req_s1.write_value;
						REG_RELOAD: reload_d = CW'(req_s1.write_value);
						REG_CMP0, REG_CMP1, REG_CMP2, REG_CMP3: begin
							for (int k = 0; k < NC; k++)
								if (chn == 4'(k) && mode_q[k][1:0] == 2'd0)
									cmp_d[k] = CW'(req_s1.write_value);
						end
						REG_SLAVE: ext_d = req_s1.write_value[14];
						default: ;
					endcase
				end
				REQ_READ: begin
					unique case (req_s1.reg_index)
						REG_CTRL: rd = {12'd0, ctrl_q};
						REG_IRQEN: rd = {7'd0, ien_q[1], 7'd0, ien_q[0]};
						REG_STATUS: rd = 16'(({chf_q, uf_q}));
						REG_MODE01, REG_MODE23: begin
							for (int i = 0; i < 2; i++) begin
								ch = (req_s1.reg_index == REG_MODE23) ? 2 + i : i;
								for (int k = 0; k < NC; k++)
									if (k == ch) rd[8*i +: 8] = mode_q[k];
							end
						end
						REG_CHEN: for (int i = 0; i < NC; i++) rd[4*i +: 4] = chen_q[i];
						REG_COUNT: rd = lo16(cnt_q);
						REG_PSC: rd = ppre_q;
						REG_RELOAD: rd = lo16(reload_q);
						REG_CMP0, REG_CMP1, REG_CMP2, REG_CMP3: begin
							for (int k = 0; k < NC; k++)
								if (chn == 4'(k)) rd = lo16(cmp_q[k]);
						end
						REG_SLAVE: rd = {1'b0, ext_q, 14'd0};
						default: rd = '0;
					endcase
				end
				default: ;
			endcase
			if (upd && !ctrl_q[1]) begin
				pact_d = ppre_q;
				if (upd_ovf || !ctrl_q[2]) begin
					uf_d = 1'b1;
					dma = ien_q[1];
				end
				if (ctrl_q[3]) ctrl_d[0] = 1'b0;
			end
			if (step)
				for (int i = 0; i < NC; i++)
					if (mode_q[i][1:0] == 2'd0 && cnt_mid == cmp_q[i]) chf_d[i] = 1'b1;
		end
		pwm = '0;
		for (int i = 0; i < NC; i++)
			if (mode_d[i][1:0] == 2'd0 && chen_d[i][0] && mode_d[i][6:4] == OC_PWM1 &&
				cnt_d < cmp_d[i])
				pwm[i] = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			reload_q <= '1;
			pcnt_q <= '0;
			ppre_q <= '0;
			pact_q <= '0;
			ctrl_q <= '0;
			ien_q <= '0;
			uf_q <= 1'b0;
			chf_q <= '0;
			pins_q <= '0;
			ext_q <= 1'b0;
			for (int i = 0; i < NC; i++) begin
				mode_q[i] <= '0;
				chen_q[i] <= '0;
				cmp_q[i] <= '0;
			end
		end else begin
			cnt_q <= cnt_d;
			reload_q <= reload_d;
			pcnt_q <= pcnt_d;
			ppre_q <= ppre_d;
			pact_q <= pact_d;
			ctrl_q <= ctrl_d;
			ien_q <= ien_d;
			uf_q <= uf_d;
			chf_q <= chf_d;
			pins_q <= pins_d;
			ext_q <= ext_d;
			mode_q <= mode_d;
			chen_q <= chen_d;
			cmp_q <= cmp_d;
		end
	end

	always_comb begin
		res = '0;
		res.read_value = rd;
		res.update_irq = uf_d & ien_d[0];
		res.dma_request = dma;
		res.pwm_outputs = pwm;
		res.capture_flags = 4'(chf_d);
		res.running = ctrl_d[0];
	end

`ifndef SYNTHESIS
	a_dma_needs_flag: assert property (@(posedge clk) disable iff (!arst_n)
		dma |=> uf_q) else $error("dma without update flag");
	a_idle_holds_count: assert property (@(posedge clk) disable iff (!arst_n)
		!req_fire |=> $stable(cnt_q)) else $error("count moved while idle");
	a_read_no_state: assert property (@(posedge clk) disable iff (!arst_n)
		(req_fire && req_s1.req_type == REQ_READ) |=> $stable(ctrl_q))
		else $error("read changed control");
`endif
endmodule

/* hw/rtl/general_purpose_timer_peripheral_core.sv */
// general purpose 16-bit timer with four capture/compare channels
// request channel: req_valid/req_stall with req_type, reg_index, write_value,
// ext_clock_edge and channel_pins; type 0 is a clock tick, 1 a register
// write, 2 a register read
// result channel: res_valid/res_stall, one result per request carrying
// read_value, update_irq, dma_request, pwm_outputs, capture_flags, running
// the request is latched in an input register, evaluated against the timer
// state combinationally, and the result lands in an output register; the
// request waits in the input register while the output register is stalled
// throughput is one request per cycle while the result is not stalled
// a stalled result holds; the input stage stalls only while it holds a
// request and the output register is full and stalled
// reset clears the timer and valid state; reload resets to all ones and no result is valid
module general_purpose_timer_peripheral_core #(
	parameter int NUM_CHANNELS = gpt_pkg::NumChannelsDef,
	parameter int COUNT_WIDTH = gpt_pkg::CountWidthDef
) (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_stall,
	input logic [1:0] req_type,
	input logic [3:0] reg_index,
	input logic [15:0] write_value,
	input logic ext_clock_edge,
	input logic [3:0] channel_pins,
	output logic res_valid,
	input logic res_stall,
	output logic [15:0] read_value,
	output logic update_irq,
	output logic dma_request,
	output logic [3:0] pwm_outputs,
	output logic [3:0] capture_flags,
	output logic running
);
	import gpt_pkg::*;

	logic v_s1, v_q, adv;
	request_t req_s1;
	result_t res, res_q;

	assign adv = v_s1 && !(v_q && res_stall);
	assign req_stall = v_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_q <= 1'b0;
		end else begin
			if (!req_stall) v_s1 <= req_valid;
			if (adv) v_q <= 1'b1;
			else if (!res_stall) v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (!req_stall && req_valid)
			req_s1 <= '{req_type, reg_index, write_value, ext_clock_edge, channel_pins};
		if (adv) res_q <= res;
	end

	gpt_core #(.NUM_CHANNELS(NUM_CHANNELS), .COUNT_WIDTH(COUNT_WIDTH)) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.req_fire(adv),
		.req_s1(req_s1),
		.res(res)
	);

	assign res_valid = v_q;
	assign read_value = res_q.read_value;
	assign update_irq = res_q.update_irq;
	assign dma_request = res_q.dma_request;
	assign pwm_outputs = res_q.pwm_outputs;
	assign capture_flags = res_q.capture_flags;
	assign running = res_q.running;

`ifndef SYNTHESIS
	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> (v_q && res_stall)) else $error("stall without full output");
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_stall) |=> res_valid) else $error("result dropped");
	a_no_loss: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !adv) |=> v_s1) else $error("request lost");
`endif
endmodule

/* tb/gpt_checker.sv */
module gpt_checker (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input logic [1:0] req_type,
	input logic [3:0] reg_index,
	input logic [15:0] write_value,
	input logic ext_clock_edge,
	input logic [3:0] channel_pins,
	input logic res_valid,
	input logic res_stall,
	input logic [15:0] read_value,
	input logic update_irq,
	input logic dma_request,
	input logic [3:0] pwm_outputs,
	input logic [3:0] capture_flags,
	input logic running,
	output int fail_count,
	output int pending
);
	import gpt_pkg::*;

	logic [15:0] cnt, psc_cnt, psc_pre, psc_act, arr;
	logic [3:0] ctl;
	logic [1:0] ien;
	logic [4:0] sr;
	logic [7:0] mode [4];
	logic [3:0] chen [4];
	logic [15:0] ccr [4];
	logic [3:0] pins_q;
	logic ext_sel;
	logic dma_hit;
	result_t timer_results [$];

	function automatic bit ch_is_input(int ch);
		return mode[ch][1:0] != 2'd0;
	endfunction

	task automatic fire_update(bit ovf);
		if (ctl[1])
			return;
		psc_act = psc_pre;
		if (ovf || !ctl[2]) begin
			sr[0] = 1'b1;
			if (ien[1])
				dma_hit = 1'b1;
		end
		if (ctl[3])
			ctl[0] = 1'b0;
	endtask

	task automatic advance_timer(logic edge_in, logic [3:0] p);
		logic prev, cur, pol, np, rise, fall;
		for (int i = 0; i < 4; i++) begin
			prev = pins_q[i];
			cur = p[i];
			pol = chen[i][1];
			np = chen[i][3];
			rise = !pol || np;
			fall = pol;
			if (ch_is_input(i) && chen[i][0] &&
				((rise && !prev && cur) || (fall && prev && !cur))) begin
				ccr[i] = cnt;
				sr[i+1] = 1'b1;
			end
		end
		pins_q = p;
		if (ctl[0] && (!ext_sel || edge_in)) begin
			if (psc_cnt >= psc_act) begin
				psc_cnt = '0;
				if (cnt == arr) begin
					cnt = '0;
					fire_update(1'b1);
				end else
					cnt = cnt + 16'd1;
				for (int i = 0; i < 4; i++)
					if (!ch_is_input(i) && cnt == ccr[i])
						sr[i+1] = 1'b1;
			end else
				psc_cnt = psc_cnt + 16'd1;
		end
	endtask

	function automatic logic [15:0] reg_contents(logic [3:0] idx);
		case (idx)
			REG_CTRL: return {12'd0, ctl};
			REG_IRQEN: return {7'd0, ien[1], 7'd0, ien[0]};
			REG_STATUS: return {11'd0, sr};
			REG_MODE01: return {mode[1], mode[0]};
			REG_MODE23: return {mode[3], mode[2]};
			REG_CHEN: return {chen[3], chen[2], chen[1], chen[0]};
			REG_COUNT: return cnt;
			REG_PSC: return psc_pre;
			REG_RELOAD: return arr;
			REG_CMP0, REG_CMP1, REG_CMP2, REG_CMP3: return ccr[idx - REG_CMP0];
			REG_SLAVE: return {1'b0, ext_sel, 14'd0};
			default: return 16'd0;
		endcase
	endfunction

	task automatic write_timer_reg(logic [3:0] idx, logic [15:0] v);
		case (idx)
			REG_CTRL: ctl = v[3:0];
			REG_IRQEN: ien = {v[8], v[0]};
			REG_STATUS: sr = sr & v[4:0];
			REG_EVENT: begin
				if (v[0]) begin
					cnt = '0;
					psc_cnt = '0;
					fire_update(1'b0);
				end
				for (int i = 0; i < 4; i++)
					if (v[i+1]) begin
						if (ch_is_input(i))
							ccr[i] = cnt;
						sr[i+1] = 1'b1;
					end
			end
			REG_MODE01: begin
				mode[0] = v[7:0];
				mode[1] = v[15:8];
			end
			REG_MODE23: begin
				mode[2] = v[7:0];
				mode[3] = v[15:8];
			end
			REG_CHEN: for (int i = 0; i < 4; i++) chen[i] = v[4*i +: 4];
			REG_COUNT: cnt = v;
			REG_PSC: psc_pre = v;
			REG_RELOAD: arr = v;
			REG_CMP0, REG_CMP1, REG_CMP2, REG_CMP3:
				if (!ch_is_input(idx - REG_CMP0))
					ccr[idx - REG_CMP0] = v;
			REG_SLAVE: ext_sel = v[14];
			default: ;
		endcase
	endtask

	task automatic predict_timer_result(request_t rq);
		result_t r;
		r = '0;
		dma_hit = 1'b0;
		case (req_t'(rq.req_type))
			REQ_TICK: advance_timer(rq.ext_clock_edge, rq.channel_pins);
			REQ_WRITE: write_timer_reg(rq.reg_index, rq.write_value);
			REQ_READ: r.read_value = reg_contents(rq.reg_index);
			default: ;
		endcase
		for (int i = 0; i < 4; i++)
			if (!ch_is_input(i) && chen[i][0] && mode[i][6:4] == OC_PWM1 && cnt < ccr[i])
				r.pwm_outputs[i] = 1'b1;
		r.update_irq = sr[0] && ien[0];
		r.dma_request = dma_hit;
		r.capture_flags = sr[4:1];
		r.running = ctl[0];
		timer_results.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			cnt = '0; psc_cnt = '0; psc_pre = '0; psc_act = '0; arr = 16'hffff;
			ctl = '0; ien = '0; sr = '0; pins_q = '0; ext_sel = 1'b0;
			for (int i = 0; i < 4; i++) begin
				mode[i] = '0;
				chen[i] = '0;
				ccr[i] = '0;
			end
			timer_results.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (res_valid && !res_stall) begin
				if (timer_results.size() == 0) begin
					$error("result with no request outstanding");
					fail_count++;
				end else begin
					want = timer_results.pop_front();
					if (read_value !== want.read_value) begin
						$error("read_value exp %h got %h", want.read_value, read_value);
						fail_count++;
					end
					if (update_irq !== want.update_irq) begin
						$error("update_irq exp %b got %b", want.update_irq, update_irq);
						fail_count++;
					end
					if (dma_request !== want.dma_request) begin
						$error("dma_request exp %b got %b", want.dma_request, dma_request);
						fail_count++;
					end
					if (pwm_outputs !== want.pwm_outputs) begin
						$error("pwm_outputs exp %h got %h", want.pwm_outputs, pwm_outputs);
						fail_count++;
					end
					if (capture_flags !== want.capture_flags) begin
						$error("capture_flags exp %h got %h", want.capture_flags,
							capture_flags);
						fail_count++;
					end
					if (running !== want.running) begin
						$error("running exp %b got %b", want.running, running);
						fail_count++;
					end
				end
			end
			if (req_valid && !req_stall)
				predict_timer_result({req_type, reg_index, write_value, ext_clock_edge,
					channel_pins});
			pending = timer_results.size();
		end
	end

endmodule

/* tb/tb_top.sv */
module tb_top;
	import gpt_pkg::*;

	logic clk, arst_n;
	logic req_valid, req_stall, res_valid, res_stall;
	logic [1:0] req_type;
	logic [3:0] reg_index;
	logic [15:0] write_value;
	logic ext_clock_edge;
	logic [3:0] channel_pins;
	logic [15:0] read_value;
	logic update_irq, dma_request, running;
	logic [3:0] pwm_outputs, capture_flags;
	int fail_count, pending;
	int send_idle_pct, recv_idle_pct;
	int quiet_cycles;

	general_purpose_timer_peripheral_core i_dut (.*);

	gpt_checker i_checker (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(negedge clk)
		res_stall <= ($urandom_range(99) < recv_idle_pct);

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (res_valid && !res_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 5000) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic send_request(logic [1:0] t, logic [3:0] idx, logic [15:0] v,
		logic e, logic [3:0] p);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req_type <= t;
		reg_index <= idx;
		write_value <= v;
		ext_clock_edge <= e;
		channel_pins <= p;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic tick(int n);
		for (int i = 0; i < n; i++)
			send_request(REQ_TICK, 4'($urandom), 16'($urandom), 1'($urandom),
				4'($urandom));
	endtask

	task automatic write_reg(logic [3:0] idx, logic [15:0] v);
		send_request(REQ_WRITE, idx, v, 1'b0, 4'd0);
	endtask

	task automatic random_request();
		int k;
		logic [15:0] v;
		k = $urandom_range(99);
		v = 16'($urandom);
		if (k < 60)
			tick(1);
		else if (k < 78)
			send_request(REQ_READ, 4'($urandom), v, 1'($urandom), 4'($urandom));
		else if (k < 80)
			send_request(REQ_NONE, 4'($urandom), v, 1'($urandom), 4'($urandom));
		else begin
			case ($urandom_range(9))
				0: v = {v[15:4], $urandom_range(4) == 0 ? v[3] : 1'b0, v[2:1], 1'b1};
				1: v[15:4] = 12'($urandom_range(1, 30) * 0);
				2: v = 16'($urandom_range(40));
				3: v = 16'($urandom_range(2));
				default: ;
			endcase
			send_request(REQ_WRITE, 4'($urandom), v, 1'($urandom), 4'($urandom));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req_type = REQ_TICK;
		reg_index = REG_CTRL;
		write_value = '0;
		ext_clock_edge = 1'b0;
		channel_pins = '0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: extremes, capture, one-pulse, overflow, unmapped
		write_reg(REG_RELOAD, 16'd5);
		write_reg(REG_MODE01, 16'h0161);
		write_reg(REG_MODE23, 16'hff01);
		write_reg(REG_CHEN, 16'hbb31);
		write_reg(REG_CMP0, 16'd3);
		write_reg(REG_CMP1, 16'hffff);
		write_reg(REG_IRQEN, 16'h0101);
		write_reg(REG_CTRL, 16'h0001);
		send_request(REQ_TICK, 4'd0, 16'd0, 1'b1, 4'hf);
		send_request(REQ_TICK, 4'd0, 16'd0, 1'b0, 4'h0);
		tick(8);
		write_reg(REG_EVENT, 16'h001f);
		write_reg(REG_STATUS, 16'h0000);
		write_reg(REG_COUNT, 16'hffff);
		tick(2);
		write_reg(REG_CTRL, 16'h000f);
		write_reg(REG_EVENT, 16'h0001);
		write_reg(REG_PSC, 16'hffff);
		write_reg(REG_SLAVE, 16'h4000);
		send_request(REQ_READ, 4'd15, 16'hffff, 1'b1, 4'hf);
		send_request(REQ_NONE, 4'd3, 16'h0, 1'b0, 4'h0);
		for (int r = 0; r < 16; r++)
			send_request(REQ_READ, 4'(r), 16'd0, 1'b0, 4'd0);
		write_reg(REG_PSC, 16'd0);
		write_reg(REG_SLAVE, 16'h0000);
		write_reg(REG_CTRL, 16'h0001);

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = phase == 0 ? 9 : (phase == 1 ? 74 : 0);
			recv_idle_pct = phase == 0 ? 74 : (phase == 1 ? 9 : 0);
			for (int n = 0; n < 567; n++) begin
				random_request();
				if (n == 300)
					drain();
			end
		end

		drain();
		repeat (10) @(negedge clk);
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

/* files.f */
hw/rtl/gpt_pkg.sv
hw/rtl/gpt_core.sv
hw/rtl/general_purpose_timer_peripheral_core.sv
tb/gpt_checker.sv
tb/tb_top.sv
